[sv/rms_pkg.sv]
package rms_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_HALL       = 3'd1,
    OP_MOVE_FWD   = 3'd2,
    OP_MOVE_BACK  = 3'd3,
    OP_STOP       = 3'd4,
    OP_CLEAR_ERR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_SPEED = 2'd1,
    ERR_STUCK    = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    MOTOR_STOPPED = 2'd0,
    MOTOR_FWD     = 2'd1,
    MOTOR_BACK    = 2'd2
  } motor_code_t;

  // internal run state, one-hot
  typedef enum logic [2:0] {
    RUN_STOP = 3'b001,
    RUN_FWD  = 3'b010,
    RUN_BACK = 3'b100
  } run_t;

  typedef enum logic [2:0] {
    REG_DEAD_TIME   = 3'd0,
    REG_STUCK_DELAY = 3'd1,
    REG_FWD_LIMIT   = 3'd2,
    REG_BACK_LIMIT  = 3'd3,
    REG_CUR_THRESH  = 3'd4,
    REG_FEATURES    = 3'd5
  } cfg_idx_t;

  localparam int CFG_BITS    = 16;
  localparam int SAMPLE_BITS = 10;
  localparam int FEAT_BITS   = 3;

  localparam logic [CFG_BITS-1:0]    DEAD_TIME_RST   = 16'd500;
  localparam logic [CFG_BITS-1:0]    STUCK_DELAY_RST = 16'd1000;
  localparam logic [CFG_BITS-1:0]    STEP_LIMIT_RST  = 16'd65535;
  localparam logic [SAMPLE_BITS-1:0] CUR_THRESH_RST  = 10'd300;
  localparam logic [FEAT_BITS-1:0]   FEATURES_RST    = 3'd7;

  localparam int FEAT_WATCHDOG = 0;
  localparam int FEAT_LIMITS   = 1;
  localparam int FEAT_STUCK    = 2;

endpackage

[sv/rms_if.sv]
interface rms_in_if;
  logic                                valid;
  logic                                ready;
  rms_pkg::op_t                        opcode;
  logic [rms_pkg::SAMPLE_BITS-1:0]     current_sample;

  modport source(output valid, opcode, current_sample, input ready);
  modport sink(input valid, opcode, current_sample, output ready);
endinterface

interface rms_out_if #(parameter int STEP_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [1:0]            motor_state;
  logic [1:0]            error_code;
  logic [STEP_BITS-1:0]  step_count;
  logic                  forward_relay;
  logic                  reverse_relay;
  logic                  power_relays;
  logic                  current_present;

  modport source(output valid, motor_state, error_code, step_count, forward_relay,
                 reverse_relay, power_relays, current_present, input ready);
  modport sink(input valid, motor_state, error_code, step_count, forward_relay,
               reverse_relay, power_relays, current_present, output ready);
endinterface

interface rms_cfg_if;
  logic                             valid;
  logic                             ready;
  rms_pkg::cfg_idx_t                index;
  logic [rms_pkg::CFG_BITS-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/relay_motor_supervisor.sv]
// path: an accepted input beat goes through the input register, then the state update
//   writes its result beat into the result register
// throughput: one item per cycle while the sink is ready; the state update is a single
//   pass of compare and saturating-increment logic, and a stalled sink holds the result
//   register and back-pressures the input; reset: rst_n synchronous active low; motor
//   stopped, no error, counters, timers and current history zero, configuration registers at their defaults
module relay_motor_supervisor #(
  parameter int HISTORY_LEN = 6,
  parameter int TIMER_BITS  = 16,
  parameter int STEP_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rms_in_if.sink      in_ch,
  rms_out_if.source   out_ch,
  rms_cfg_if.sink     cfg_ch
);
  import rms_pkg::*;

  localparam int TCW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam int SCW = (STEP_BITS > CFG_BITS) ? STEP_BITS : CFG_BITS;
  localparam int HCW = $clog2(HISTORY_LEN + 1);

  // configuration
  logic [CFG_BITS-1:0]    dead_time_r, stuck_delay_r, fwd_limit_r, back_limit_r;
  logic [SAMPLE_BITS-1:0] cur_thresh_r;
  logic [FEAT_BITS-1:0]   features_r;

  // input register
  logic                   item_v_r;
  op_t                    item_op_r;
  logic [SAMPLE_BITS-1:0] item_sample_r;

  // supervisor state
  run_t                   run_r, run_nxt;
  err_t                   fault_r, fault_nxt;
  logic [STEP_BITS-1:0]   steps_r, steps_nxt;
  logic                   pulse_seen_r, pulse_seen_nxt;
  logic [TIMER_BITS-1:0]  window_r, window_nxt;
  logic [TIMER_BITS-1:0]  since_stop_r, since_stop_nxt;
  logic [HISTORY_LEN-1:0] hist_r, hist_nxt;

  // result register
  logic                   out_v_r;

  logic                   adv;
  logic                   in_fire;
  logic [HISTORY_LEN:0]   hist_shift;
  logic [HCW-1:0]         hist_cnt;
  logic                   maj_nxt;

  assign adv       = item_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !item_v_r || adv;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;

  always_comb begin
    run_nxt        = run_r;
    fault_nxt      = fault_r;
    steps_nxt      = steps_r;
    pulse_seen_nxt = pulse_seen_r;
    window_nxt     = window_r;
    since_stop_nxt = since_stop_r;
    hist_nxt       = hist_r;
    hist_shift     = {hist_r, (item_sample_r > cur_thresh_r)};
    hist_cnt       = HCW'($countones(hist_shift[HISTORY_LEN-1:0]));
    maj_nxt        = 1'b0;

    case (item_op_r)
      OP_TICK: begin
        hist_nxt = hist_shift[HISTORY_LEN-1:0];
        maj_nxt  = ({1'b0, hist_cnt, 1'b0} > (HCW + 2)'(HISTORY_LEN));
        if (run_r != RUN_STOP) begin
          if (window_r != '1) window_nxt = window_r + 1'b1;
          if (features_r[FEAT_WATCHDOG] &&
              (TCW'(window_nxt) > TCW'(dead_time_r))) begin
            window_nxt = '0;
            if (pulse_seen_r) begin
              pulse_seen_nxt = 1'b0;
            end else begin
              run_nxt        = RUN_STOP;
              since_stop_nxt = '0;
              fault_nxt      = ERR_NO_SPEED;
            end
          end
          // limit check sees the run state after a possible watchdog stop
          if (features_r[FEAT_LIMITS]) begin
            if ((run_nxt == RUN_FWD && SCW'(steps_r) >= SCW'(fwd_limit_r)) ||
                (run_nxt == RUN_BACK && SCW'(steps_r) >= SCW'(back_limit_r))) begin
              run_nxt        = RUN_STOP;
              since_stop_nxt = '0;
            end
          end
        end else begin
          if (since_stop_r != '1) since_stop_nxt = since_stop_r + 1'b1;
          if (features_r[FEAT_STUCK] && maj_nxt &&
              (TCW'(since_stop_nxt) > TCW'(stuck_delay_r))) begin
            fault_nxt = ERR_STUCK;
          end
        end
      end
      OP_HALL: begin
        if (run_r != RUN_STOP) begin
          if (steps_r != '1) steps_nxt = steps_r + 1'b1;
          pulse_seen_nxt = 1'b1;
        end
      end
      OP_MOVE_FWD, OP_MOVE_BACK: begin
        run_nxt        = (item_op_r == OP_MOVE_FWD) ? RUN_FWD : RUN_BACK;
        steps_nxt      = '0;
        window_nxt     = '0;
        pulse_seen_nxt = 1'b1;
      end
      OP_STOP: begin
        run_nxt        = RUN_STOP;
        since_stop_nxt = '0;
      end
      OP_CLEAR_ERR: fault_nxt = ERR_NONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_time_r   <= DEAD_TIME_RST;
      stuck_delay_r <= STUCK_DELAY_RST;
      fwd_limit_r   <= STEP_LIMIT_RST;
      back_limit_r  <= STEP_LIMIT_RST;
      cur_thresh_r  <= CUR_THRESH_RST;
      features_r    <= FEATURES_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEAD_TIME:   dead_time_r   <= cfg_ch.data;
        REG_STUCK_DELAY: stuck_delay_r <= cfg_ch.data;
        REG_FWD_LIMIT:   fwd_limit_r   <= cfg_ch.data;
        REG_BACK_LIMIT:  back_limit_r  <= cfg_ch.data;
        REG_CUR_THRESH:  cur_thresh_r  <= cfg_ch.data[SAMPLE_BITS-1:0];
        REG_FEATURES:    features_r    <= cfg_ch.data[FEAT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      run_r        <= RUN_STOP;
      fault_r      <= ERR_NONE;
      steps_r      <= '0;
      pulse_seen_r <= 1'b0;
      window_r     <= '0;
      since_stop_r <= '0;
      hist_r       <= '0;
    end else begin
      if (in_ch.ready) item_v_r <= in_ch.valid;
      if (adv) begin
        out_v_r      <= 1'b1;
        run_r        <= run_nxt;
        fault_r      <= fault_nxt;
        steps_r      <= steps_nxt;
        pulse_seen_r <= pulse_seen_nxt;
        window_r     <= window_nxt;
        since_stop_r <= since_stop_nxt;
        hist_r       <= hist_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op_r     <= in_ch.opcode;
      item_sample_r <= in_ch.current_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case (run_nxt)
        RUN_FWD:  out_ch.motor_state <= MOTOR_FWD;
        RUN_BACK: out_ch.motor_state <= MOTOR_BACK;
        default:  out_ch.motor_state <= MOTOR_STOPPED;
      endcase
      out_ch.error_code      <= fault_nxt;
      out_ch.step_count      <= steps_nxt;
      out_ch.forward_relay   <= (run_nxt == RUN_FWD);
      out_ch.reverse_relay   <= (run_nxt == RUN_BACK);
      out_ch.power_relays    <= (run_nxt != RUN_STOP);
      out_ch.current_present <=
        ({1'b0, HCW'($countones(hist_nxt)), 1'b0} > (HCW + 2)'(HISTORY_LEN));
    end
  end

  a_run_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(run_r))
    else $error("run state lost its one-hot code");

  a_relays_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_ch.forward_relay && out_ch.reverse_relay))
    else $error("both direction relays energized");

  a_power_follows_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_ch.power_relays == (out_ch.forward_relay || out_ch.reverse_relay)))
    else $error("power relays disagree with direction relays");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r)
    else $error("stalled result beat dropped");

  a_error_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r == ERR_NONE) || (fault_r == ERR_NO_SPEED) || (fault_r == ERR_STUCK))
    else $error("illegal fault code");

endmodule
